FILE: hdl/ecu_pkg.sv
package ecu_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int OUT_W    = 32;
  localparam int IDX_W    = 5;
  localparam int TS_W     = 32;

  // Coefficient table layout
  localparam int NUM_COEF    = 21;
  localparam int SLOT_MIS    = 3;
  localparam int SLOT_ABIAS  = 12;
  localparam int SLOT_GSCALE = 15;
  localparam int SLOT_GBIAS  = 18;

  // Datapath widths: matrix entry, cofactor, accumulator
  localparam int MW = 34;
  localparam int CW = 69;
  localparam int NW = 105;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_SAMPLE = 1'b1
  } ecu_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COF,
    ST_DET,
    ST_NUM,
    ST_DIV,
    ST_GYRO,
    ST_INC,
    ST_OUT0,
    ST_OUT1
  } ecu_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_RUN,
    DV_FIN
  } ecu_div_state_e;

  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
  } ecu_mac_cmd_t;

  // Clamp an accumulator value to the signed 32-bit range
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [NW-1:0] x);
    logic signed [NW-1:0] hi;
    logic signed [NW-1:0] lo;
    hi = NW'(64'sd2147483647);
    lo = -hi - NW'(64'sd1);
    if (x > hi) begin
      return 32'sh7FFFFFFF;
    end else if (x < lo) begin
      return 32'sh80000000;
    end else begin
      return signed'(x[OUT_W-1:0]);
    end
  endfunction

endpackage

FILE: hdl/ecu_mac.sv
module ecu_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ecu_pkg::ecu_mac_cmd_t          cmd_i,
  input  logic signed [ecu_pkg::MW-1:0]  a_i,
  input  logic signed [ecu_pkg::CW-1:0]  b_i,
  output logic                           busy_o,
  output logic signed [ecu_pkg::NW-1:0]  acc_o
);
  import ecu_pkg::*;

  logic                 busy_q, busy_d;
  logic [MW-1:0]        amag_q, amag_d, a_abs;
  logic signed [NW-1:0] bsh_q, bsh_d, acc_q, acc_d, b_ext;
  logic                 neg;

  // Shift-add multiply-accumulate, one multiplier bit per cycle
  always_comb begin
    neg    = a_i[MW-1] ^ cmd_i.sub;
    a_abs  = a_i[MW-1] ? MW'(-a_i) : a_i;
    b_ext  = NW'(b_i);
    busy_d = busy_q;
    amag_d = amag_q;
    bsh_d  = bsh_q;
    acc_d  = acc_q;
    if (cmd_i.start) begin
      amag_d = a_abs;
      bsh_d  = neg ? -b_ext : b_ext;
      if (cmd_i.clear) acc_d = '0;
      busy_d = (a_abs != '0);
    end else if (busy_q) begin
      if (amag_q[0]) acc_d = acc_q + bsh_q;
      bsh_d  = bsh_q << 1;
      amag_d = amag_q >> 1;
      busy_d = (amag_q[MW-1:1] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amag_q <= amag_d;
    bsh_q  <= bsh_d;
    acc_q  <= acc_d;
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

FILE: hdl/ecu_div.sv
module ecu_div #(
  parameter int NUM_W = 135
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [NUM_W-1:0]         num_i,
  input  logic signed [ecu_pkg::NW-1:0]   den_i,
  output logic                            busy_o,
  output logic signed [ecu_pkg::OUT_W-1:0] quot_o
);
  import ecu_pkg::*;

  localparam int DW    = NUM_W + 1;
  localparam int RW    = NW + 2;
  localparam int CNT_W = $clog2(DW + 1);

  ecu_div_state_e          st_q, st_d;
  logic                    neg_q;
  logic [NUM_W-1:0]        an_q;
  logic [NW-1:0]           ad_q;
  logic [DW-1:0]           num_q;
  logic [NW:0]             den_q;
  logic [RW-1:0]           rem_q, r_sh, r_nx;
  logic [OUT_W-1:0]        q_q;
  logic                    ovf_q, ge;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [OUT_W-1:0] quot_q;
  logic [OUT_W:0]          lim, q33, mag, sgn;

  // Restoring division step and final rounding clamp
  always_comb begin
    r_sh = {rem_q[RW-2:0], num_q[DW-1]};
    ge   = (r_sh >= RW'(den_q));
    r_nx = ge ? r_sh - RW'(den_q) : r_sh;
    lim  = neg_q ? 33'h080000000 : 33'h07FFFFFFF;
    q33  = {1'b0, q_q};
    mag  = (ovf_q || (q33 > lim)) ? lim : q33;
    sgn  = neg_q ? -mag : mag;
  end

  // Sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      DV_IDLE: if (start_i) st_d = DV_PREP;
      DV_PREP: st_d = DV_RUN;
      DV_RUN:  if (cnt_q == CNT_W'(1)) st_d = DV_FIN;
      DV_FIN:  st_d = DV_IDLE;
      default: st_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DV_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      DV_IDLE: begin
        if (start_i) begin
          neg_q <= num_i[NUM_W-1] ^ den_i[NW-1];
          an_q  <= num_i[NUM_W-1] ? NUM_W'(-num_i) : num_i;
          ad_q  <= den_i[NW-1] ? NW'(-den_i) : den_i;
        end
      end
      DV_PREP: begin
        // 2|n| + |d| over 2|d| gives round half away from zero
        num_q <= {an_q, 1'b0} + DW'(ad_q);
        den_q <= {ad_q, 1'b0};
        rem_q <= '0;
        q_q   <= '0;
        ovf_q <= 1'b0;
        cnt_q <= CNT_W'(DW);
      end
      DV_RUN: begin
        rem_q <= r_nx;
        num_q <= num_q << 1;
        ovf_q <= ovf_q | q_q[OUT_W-1];
        q_q   <= {q_q[OUT_W-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      DV_FIN:  quot_q <= signed'(sgn[OUT_W-1:0]);
      default: ;
    endcase
  end

  assign busy_o = (st_q != DV_IDLE);
  assign quot_o = quot_q;

endmodule

FILE: hdl/imu_error_compensation_unit.sv
// IMU error compensation. Load items (mode 0) write one word of the 21-word
// coefficient table and give no result. A sample item
// (mode 1) corrects the accelerometer by M^-1 (raw - bias) using cofactors
// and Cramer's rule, and the gyro by its diagonal scale, with round-to-nearest
// division and 32-bit saturation. With a nonzero time_step a second result
// carries the increments value * time_step >> 16. The block takes one item
// at a time: ready is low from sample accept until the last result is taken.
// The work is up to 36 multiply-accumulates on one shift-add unit, which
// steps through the bits of the multiplier magnitude (at most 34 bits) and
// stops early once the rest is zero, and up to six divisions on one
// restoring divider. A division on a singular matrix is skipped, and a
// zero time_step skips the increments.
module imu_error_compensation_unit #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                time_step_we_i,
  input  logic [31:0]                         time_step_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [ecu_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [ecu_pkg::COEF_W-1:0]   coef_value_i,
  input  logic signed [ecu_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [ecu_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [ecu_pkg::SAMPLE_W-1:0] accel_z_i,
  input  logic signed [ecu_pkg::SAMPLE_W-1:0] gyro_x_i,
  input  logic signed [ecu_pkg::SAMPLE_W-1:0] gyro_y_i,
  input  logic signed [ecu_pkg::SAMPLE_W-1:0] gyro_z_i,
  input  logic [ecu_pkg::TS_W-1:0]            timestamp_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic signed [ecu_pkg::OUT_W-1:0]    accel_out_x_o,
  output logic signed [ecu_pkg::OUT_W-1:0]    accel_out_y_o,
  output logic signed [ecu_pkg::OUT_W-1:0]    accel_out_z_o,
  output logic signed [ecu_pkg::OUT_W-1:0]    gyro_out_x_o,
  output logic signed [ecu_pkg::OUT_W-1:0]    gyro_out_y_o,
  output logic signed [ecu_pkg::OUT_W-1:0]    gyro_out_z_o,
  output logic                                singular_o,
  output logic                                last_of_run_o,
  output logic [ecu_pkg::TS_W-1:0]            timestamp_out_o
);
  import ecu_pkg::*;

  localparam int NUM_W = NW + COEF_FRAC_BITS;
  localparam logic signed [MW-1:0] ONE = MW'(1) << COEF_FRAC_BITS;

  // Take the low SAMPLE_BITS bits of a raw field, sign extended
  function automatic logic signed [MW-1:0] samp(input logic [SAMPLE_W-1:0] raw);
    logic [31:0]        z;
    logic signed [31:0] s;
    z = 32'(raw);
    s = signed'(z << (32 - SAMPLE_BITS)) >>> (32 - SAMPLE_BITS);
    return MW'(s);
  endfunction

  // Configuration and coefficient table
  logic [31:0]               time_step_q;
  logic signed [COEF_W-1:0]  coef_q [NUM_COEF];
  logic                      load_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NUM_COEF; n++) coef_q[n] <= '0;
      time_step_q <= '0;
    end else begin
      if (time_step_we_i) time_step_q <= time_step_i;
      if (load_we && (coef_index_i < IDX_W'(NUM_COEF))) coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // Operand values formed at sample accept
  logic [SAMPLE_W-1:0]       acc_raw [3];
  logic [SAMPLE_W-1:0]       gyr_raw [3];
  logic signed [MW-1:0]      m_cap [3][3];
  logic signed [MW-1:0]      v_cap [3];
  logic signed [MW-1:0]      g_cap [3];
  logic signed [MW-1:0]      gv_cap [3];
  logic                      gsing_cap;

  assign acc_raw[0] = accel_x_i;
  assign acc_raw[1] = accel_y_i;
  assign acc_raw[2] = accel_z_i;
  assign gyr_raw[0] = gyro_x_i;
  assign gyr_raw[1] = gyro_y_i;
  assign gyr_raw[2] = gyro_z_i;

  always_comb begin
    gsing_cap = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) m_cap[r][c] = MW'(coef_q[SLOT_MIS + 3 * r + c]);
      m_cap[r][r] = m_cap[r][r] + ONE + MW'(coef_q[r]);
      v_cap[r]    = samp(acc_raw[r]) - MW'(coef_q[SLOT_ABIAS + r]);
      g_cap[r]    = ONE + MW'(coef_q[SLOT_GSCALE + r]);
      gv_cap[r]   = samp(gyr_raw[r]) - MW'(coef_q[SLOT_GBIAS + r]);
      if (g_cap[r] == '0) gsing_cap = 1'b1;
    end
  end

  // Working registers
  logic signed [MW-1:0]    m_q [3][3];
  logic signed [MW-1:0]    v_q [3];
  logic signed [MW-1:0]    g_q [3];
  logic signed [MW-1:0]    gv_q [3];
  logic signed [CW-1:0]    cof_q [3][3];
  logic signed [NW-1:0]    det_q;
  logic signed [OUT_W-1:0] res_q [6];
  logic signed [OUT_W-1:0] inc_q [6];
  logic                    gsing_q;
  logic [TS_W-1:0]         ts_q;

  // Sequencer state
  ecu_state_e  state_q, state_d;
  logic [2:0]  i_q, i_d;
  logic [1:0]  c_q, c_d, k_q, k_d;
  logic        half_q, half_d, wait_q, wait_d;

  // Shared units
  ecu_mac_cmd_t            mac_cmd;
  logic signed [MW-1:0]    mac_a;
  logic signed [CW-1:0]    mac_b;
  logic                    mac_busy;
  logic signed [NW-1:0]    mac_acc;
  logic                    div_start, div_busy;
  logic signed [NUM_W-1:0] div_num;
  logic signed [NW-1:0]    div_den;
  logic signed [OUT_W-1:0] div_quot;

  ecu_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  ecu_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // Cofactor row/column pairs
  logic [1:0] row, ra, rb, ca, cb;
  logic       odd, det_zero, cap, cof_we, det_we, res_we, inc_we;
  logic [2:0] res_idx;
  logic signed [OUT_W-1:0] res_val;

  assign row      = i_q[1:0];
  assign ra       = (row == 2'd0) ? 2'd1 : 2'd0;
  assign rb       = (row == 2'd2) ? 2'd1 : 2'd2;
  assign ca       = (c_q == 2'd0) ? 2'd1 : 2'd0;
  assign cb       = (c_q == 2'd2) ? 2'd1 : 2'd2;
  assign odd      = row[0] ^ c_q[0];
  assign det_zero = (det_q == '0);

  // Next state and datapath control
  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    c_d        = c_q;
    k_d        = k_q;
    half_d     = half_q;
    wait_d     = wait_q;
    mac_cmd    = '0;
    mac_a      = '0;
    mac_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    cap        = 1'b0;
    load_we    = 1'b0;
    cof_we     = 1'b0;
    det_we     = 1'b0;
    res_we     = 1'b0;
    res_idx    = '0;
    res_val    = '0;
    inc_we     = 1'b0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == MODE_SAMPLE) begin
            cap     = 1'b1;
            state_d = ST_COF;
            i_d     = '0;
            c_d     = '0;
            half_d  = 1'b0;
            wait_d  = 1'b0;
          end else begin
            load_we = 1'b1;
          end
        end
      end
      // Signed 2x2 minors: two products per cofactor
      ST_COF: begin
        mac_a         = half_q ? m_q[ra][cb] : m_q[ra][ca];
        mac_b         = CW'(half_q ? m_q[rb][ca] : m_q[rb][cb]);
        mac_cmd.clear = !half_q;
        mac_cmd.sub   = half_q ^ odd;
        if (!wait_q) begin
          mac_cmd.start = 1'b1;
          wait_d        = 1'b1;
        end else if (!mac_busy) begin
          wait_d = 1'b0;
          if (half_q) begin
            cof_we = 1'b1;
            half_d = 1'b0;
            if (c_q == 2'd2) begin
              c_d = '0;
              if (row == 2'd2) begin
                i_d     = '0;
                state_d = ST_DET;
              end else begin
                i_d = i_q + 3'd1;
              end
            end else begin
              c_d = c_q + 2'd1;
            end
          end else begin
            half_d = 1'b1;
          end
        end
      end
      // Determinant by expansion along row 0
      ST_DET: begin
        mac_a         = m_q[0][c_q];
        mac_b         = cof_q[0][c_q];
        mac_cmd.clear = (c_q == 2'd0);
        if (!wait_q) begin
          mac_cmd.start = 1'b1;
          wait_d        = 1'b1;
        end else if (!mac_busy) begin
          wait_d = 1'b0;
          if (c_q == 2'd2) begin
            det_we  = 1'b1;
            c_d     = '0;
            i_d     = '0;
            k_d     = '0;
            state_d = ST_NUM;
          end else begin
            c_d = c_q + 2'd1;
          end
        end
      end
      // Cramer numerator for accel axis k
      ST_NUM: begin
        mac_a         = v_q[row];
        mac_b         = cof_q[row][k_q];
        mac_cmd.clear = (row == 2'd0);
        if (!wait_q) begin
          mac_cmd.start = 1'b1;
          wait_d        = 1'b1;
        end else if (!mac_busy) begin
          wait_d = 1'b0;
          if (row == 2'd2) begin
            i_d     = '0;
            state_d = ST_DIV;
          end else begin
            i_d = i_q + 3'd1;
          end
        end
      end
      ST_DIV: begin
        div_num = {mac_acc, {COEF_FRAC_BITS{1'b0}}};
        div_den = det_q;
        res_idx = {1'b0, k_q};
        if (det_zero || (wait_q && !div_busy)) begin
          res_we  = 1'b1;
          res_val = det_zero ? '0 : div_quot;
          wait_d  = 1'b0;
          i_d     = '0;
          if (k_q == 2'd2) begin
            state_d = ST_GYRO;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ST_NUM;
          end
        end else if (!wait_q) begin
          div_start = 1'b1;
          wait_d    = 1'b1;
        end
      end
      ST_GYRO: begin
        div_num = {NW'(gv_q[row]), {COEF_FRAC_BITS{1'b0}}};
        div_den = NW'(g_q[row]);
        res_idx = 3'd3 + {1'b0, row};
        if (gsing_q || (wait_q && !div_busy)) begin
          res_we  = 1'b1;
          res_val = gsing_q ? '0 : div_quot;
          wait_d  = 1'b0;
          if (row == 2'd2) begin
            i_d     = '0;
            state_d = ST_INC;
          end else begin
            i_d = i_q + 3'd1;
          end
        end else if (!wait_q) begin
          div_start = 1'b1;
          wait_d    = 1'b1;
        end
      end
      // Increments: value * time_step, floor shift by 16
      ST_INC: begin
        mac_a         = MW'(time_step_q);
        mac_b         = CW'(res_q[i_q]);
        mac_cmd.clear = 1'b1;
        if (time_step_q == '0) begin
          state_d = ST_OUT0;
        end else if (!wait_q) begin
          mac_cmd.start = 1'b1;
          wait_d        = 1'b1;
        end else if (!mac_busy) begin
          wait_d = 1'b0;
          inc_we = 1'b1;
          if (i_q == 3'd5) begin
            i_d     = '0;
            state_d = ST_OUT0;
          end else begin
            i_d = i_q + 3'd1;
          end
        end
      end
      ST_OUT0: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = (time_step_q != '0) ? ST_OUT1 : ST_IDLE;
      end
      ST_OUT1: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      half_q  <= 1'b0;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      c_q     <= c_d;
      k_q     <= k_d;
      half_q  <= half_d;
      wait_q  <= wait_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cap) begin
      m_q     <= m_cap;
      v_q     <= v_cap;
      g_q     <= g_cap;
      gv_q    <= gv_cap;
      gsing_q <= gsing_cap;
      ts_q    <= timestamp_i;
    end
    if (cof_we) cof_q[row][c_q] <= mac_acc[CW-1:0];
    if (det_we) det_q <= mac_acc;
    if (res_we) res_q[res_idx] <= res_val;
    if (inc_we) inc_q[i_q] <= sat32(mac_acc >>> 16);
  end

  // Result ports
  assign kind_o          = (state_q == ST_OUT1);
  assign last_of_run_o   = (state_q == ST_OUT1) || (time_step_q == '0);
  assign singular_o      = det_zero | gsing_q;
  assign timestamp_out_o = ts_q;
  assign accel_out_x_o   = kind_o ? inc_q[0] : res_q[0];
  assign accel_out_y_o   = kind_o ? inc_q[1] : res_q[1];
  assign accel_out_z_o   = kind_o ? inc_q[2] : res_q[2];
  assign gyro_out_x_o    = kind_o ? inc_q[3] : res_q[3];
  assign gyro_out_y_o    = kind_o ? inc_q[4] : res_q[4];
  assign gyro_out_z_o    = kind_o ? inc_q[5] : res_q[5];

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_inc_needs_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> (time_step_q != '0))
    else $error("increment result with zero time step");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_run_o) |=> (out_valid_o && kind_o))
    else $error("increment item did not follow the rate item");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mac_busy && div_busy))
    else $error("multiplier and divider busy together");

endmodule

FILE: sim/imu_error_compensation_unit_test.sv
module imu_error_compensation_unit_test;
  import ecu_pkg::*;

  localparam logic signed [63:0] ONE_Q30 = 64'sd1 <<< 30;

  typedef logic signed [191:0] wide_t;
  typedef logic signed [63:0] mat_t [3][3];

  typedef struct {
    ecu_mode_e          mode;
    logic [4:0]         idx;
    logic signed [31:0] value;
    logic signed [23:0] acc [3];
    logic signed [23:0] gyr [3];
    logic [31:0]        ts;
  } imu_item_t;

  typedef struct {
    logic               kind;
    logic signed [31:0] val [6];
    logic               sing;
    logic               last;
    logic [31:0]        ts;
  } imu_result_t;

  // Corrected-sample predictor plus the queue of results it still owes
  class imu_scoreboard;
    logic [31:0] coef_tab [NUM_COEF];
    logic [31:0] step;
    imu_result_t owed_q [$];
    int errors;

    function new();
      foreach (coef_tab[k]) coef_tab[k] = '0;
      step = '0;
      errors = 0;
    endfunction

    function logic signed [63:0] coef(int k);
      return 64'($signed(coef_tab[k]));
    endfunction

    function wide_t det3(mat_t m);
      wide_t d;
      d = wide_t'(m[0][0]) * wide_t'(m[1][1]) * wide_t'(m[2][2]);
      d = d - wide_t'(m[0][0]) * wide_t'(m[1][2]) * wide_t'(m[2][1]);
      d = d - wide_t'(m[0][1]) * wide_t'(m[1][0]) * wide_t'(m[2][2]);
      d = d + wide_t'(m[0][1]) * wide_t'(m[1][2]) * wide_t'(m[2][0]);
      d = d + wide_t'(m[0][2]) * wide_t'(m[1][0]) * wide_t'(m[2][1]);
      d = d - wide_t'(m[0][2]) * wide_t'(m[1][1]) * wide_t'(m[2][0]);
      return d;
    endfunction

    // n/d rounded half away from zero, clamped to 32 bits
    function logic signed [31:0] div_round(wide_t n, wide_t d);
      logic neg;
      logic [191:0] an, ad, q, lim;
      neg = (n < 0) ^ (d < 0);
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = ((an << 1) + ad) / (ad << 1);
      lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
      if (q > lim) q = lim;
      return neg ? 32'(-q) : 32'(q);
    endfunction

    function logic signed [31:0] incr(logic signed [31:0] c);
      logic signed [63:0] p;
      p = 64'(c) * $signed({32'b0, step});
      p = p >>> 16;
      if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
      if (p < -64'sh8000_0000) p = -64'sh8000_0000;
      return p[31:0];
    endfunction

    function void set_step(logic [31:0] s);
      step = s;
    endfunction

    function void note_item(imu_item_t it);
      mat_t m, mk;
      logic signed [63:0] v [3];
      logic signed [63:0] g, gv;
      logic signed [31:0] res [6];
      wide_t det;
      logic sing, gsing;
      imu_result_t r;
      if (it.mode == MODE_LOAD) begin
        if (it.idx < NUM_COEF) coef_tab[it.idx] = it.value;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) m[i][j] = coef(SLOT_MIS + 3 * i + j);
        m[i][i] += ONE_Q30 + coef(i);
        v[i] = 64'(it.acc[i]) - coef(SLOT_ABIAS + i);
      end
      det = det3(m);
      sing = (det == 0);
      for (int k = 0; k < 3; k++) begin
        mk = m;
        for (int i = 0; i < 3; i++) mk[i][k] = v[i];
        res[k] = sing ? 32'sd0 : div_round(det3(mk) * wide_t'(ONE_Q30), det);
      end
      // gyro: diagonal scale only, any zero diagonal blanks all three axes
      gsing = 1'b0;
      for (int i = 0; i < 3; i++)
        if (ONE_Q30 + coef(SLOT_GSCALE + i) == 0) gsing = 1'b1;
      for (int i = 0; i < 3; i++) begin
        g = ONE_Q30 + coef(SLOT_GSCALE + i);
        gv = 64'(it.gyr[i]) - coef(SLOT_GBIAS + i);
        res[3 + i] = gsing ? 32'sd0 : div_round(wide_t'(gv) * wide_t'(ONE_Q30), wide_t'(g));
      end
      sing |= gsing;
      r.kind = 1'b0;
      r.val = res;
      r.sing = sing;
      r.last = (step == 0);
      r.ts = it.ts;
      owed_q = {owed_q, r};
      if (step != 0) begin
        r.kind = 1'b1;
        foreach (r.val[i]) r.val[i] = incr(res[i]);
        r.last = 1'b1;
        owed_q = {owed_q, r};
      end
    endfunction

    function void check_result(imu_result_t got);
      imu_result_t exp_r;
      logic bad;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result ts=%h", got.ts);
        return;
      end
      exp_r = owed_q.pop_front();
      bad = (got.kind !== exp_r.kind) || (got.sing !== exp_r.sing) ||
            (got.last !== exp_r.last) || (got.ts !== exp_r.ts);
      foreach (got.val[i]) if (got.val[i] !== exp_r.val[i]) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: ts=%h exp k=%0d s=%0d l=%0d %0d %0d %0d %0d %0d %0d",
                   exp_r.ts, exp_r.kind, exp_r.sing, exp_r.last, exp_r.val[0], exp_r.val[1],
                   exp_r.val[2], exp_r.val[3], exp_r.val[4], exp_r.val[5]);
          $display("  got ts=%h k=%0d s=%0d l=%0d %0d %0d %0d %0d %0d %0d",
                   got.ts, got.kind, got.sing, got.last, got.val[0], got.val[1],
                   got.val[2], got.val[3], got.val[4], got.val[5]);
        end
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic time_step_we_i;
  logic [31:0] time_step_i;
  logic in_valid_i, in_ready_o, mode_i;
  logic [IDX_W-1:0] coef_index_i;
  logic signed [COEF_W-1:0] coef_value_i;
  logic signed [SAMPLE_W-1:0] accel_x_i, accel_y_i, accel_z_i, gyro_x_i, gyro_y_i, gyro_z_i;
  logic [TS_W-1:0] timestamp_i;
  logic out_valid_o, out_ready_i, kind_o, singular_o, last_of_run_o;
  logic signed [OUT_W-1:0] accel_out_x_o, accel_out_y_o, accel_out_z_o;
  logic signed [OUT_W-1:0] gyro_out_x_o, gyro_out_y_o, gyro_out_z_o;
  logic [TS_W-1:0] timestamp_out_o;

  imu_error_compensation_unit u_dut (.*);

  imu_scoreboard sb;
  logic calm;
  logic [31:0] ts_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 40_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stalls, one long hold-off, one calm stretch
  initial begin
    int cyc;
    cyc = 0;
    calm <= 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      calm <= (cyc >= 60000 && cyc < 90000);
      if (cyc >= 30000 && cyc < 36000) out_ready_i <= 1'b0;
      else out_ready_i <= calm || ($urandom_range(99) >= 35);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    imu_result_t got;
    if (rst_ni && sb != null && out_valid_o && out_ready_i) begin
      got.kind = kind_o;
      got.val = '{accel_out_x_o, accel_out_y_o, accel_out_z_o,
                  gyro_out_x_o, gyro_out_y_o, gyro_out_z_o};
      got.sing = singular_o;
      got.last = last_of_run_o;
      got.ts = timestamp_out_o;
      sb.check_result(got);
    end
  end

  function automatic logic gap_roll();
    return !calm && ($urandom_range(99) < 35);
  endfunction

  task automatic send_item(imu_item_t it);
    if (gap_roll()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (gap_roll()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= it.mode;
    coef_index_i <= it.idx;
    coef_value_i <= it.value;
    accel_x_i <= it.acc[0];
    accel_y_i <= it.acc[1];
    accel_z_i <= it.acc[2];
    gyro_x_i <= it.gyr[0];
    gyro_y_i <= it.gyr[1];
    gyro_z_i <= it.gyr[2];
    timestamp_i <= it.ts;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    sb.note_item(it);
  endtask

  task automatic load_coef(int idx, logic [31:0] val);
    imu_item_t it;
    it.mode = MODE_LOAD;
    it.idx = idx[4:0];
    it.value = val;
    foreach (it.acc[i]) begin
      it.acc[i] = 24'($urandom);
      it.gyr[i] = 24'($urandom);
    end
    it.ts = $urandom;
    send_item(it);
  endtask

  task automatic send_sample(logic signed [23:0] a0, a1, a2, g0, g1, g2);
    imu_item_t it;
    it.mode = MODE_SAMPLE;
    it.idx = 5'($urandom);
    it.value = $urandom;
    it.acc = '{a0, a1, a2};
    it.gyr = '{g0, g1, g2};
    it.ts = ts_cnt;
    ts_cnt = ts_cnt + $urandom_range(1, 3000);
    send_item(it);
  endtask

  function automatic logic signed [23:0] raw_rand();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
      default: return 24'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  task automatic random_sample();
    send_sample(raw_rand(), raw_rand(), raw_rand(), raw_rand(), raw_rand(), raw_rand());
  endtask

  // Register write once all owed results are out
  task automatic write_step(logic [31:0] s);
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    time_step_we_i <= 1'b1;
    time_step_i <= s;
    sb.set_step(s);
    @(posedge clk_i);
    time_step_we_i <= 1'b0;
  endtask

  // Realistic coefficient for a slot, with rare extremes
  function automatic logic [31:0] coef_rand(int idx);
    if ($urandom_range(19) == 0) return $urandom;
    if (idx < SLOT_MIS) return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
    if (idx < SLOT_ABIAS) return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    if (idx < SLOT_GSCALE) return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    if (idx < SLOT_GBIAS) return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
    return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  task automatic random_phase(int n_items);
    int sent, nl, ns;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        // noise: any slot, any word, unused slots too
        load_coef($urandom_range(31), $urandom);
        sent++;
      end else begin
        nl = $urandom_range(0, 4);
        ns = $urandom_range(1, 3);
        repeat (nl) begin
          int k;
          k = $urandom_range(NUM_COEF - 1);
          load_coef(k, coef_rand(k));
        end
        repeat (ns) random_sample();
        sent += nl + ns;
      end
    end
  endtask

  initial begin
    sb = new();
    ts_cnt = 32'h0000_1000;
    rst_ni <= 1'b0;
    time_step_we_i <= 1'b0;
    time_step_i <= '0;
    in_valid_i <= 1'b0;
    mode_i <= MODE_LOAD;
    coef_index_i <= '0;
    coef_value_i <= '0;
    accel_x_i <= '0;
    accel_y_i <= '0;
    accel_z_i <= '0;
    gyro_x_i <= '0;
    gyro_y_i <= '0;
    gyro_z_i <= '0;
    timestamp_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity table, full-range samples, largest step
    write_step(32'hFFFF_FFFF);
    send_sample(24'sh7FFFFF, -24'sh800000, 24'sd0, -24'sh800000, 24'sh7FFFFF, -24'sd1);
    load_coef(21, 32'hDEAD_BEEF);
    load_coef(31, 32'h1234_5678);
    send_sample(24'sd5, -24'sd5, 24'sd1, 24'sd3, -24'sd3, 24'sd0);
    // singular gyro: 1 + S_g is zero
    load_coef(SLOT_GSCALE + 1, 32'hC000_0000);
    send_sample(24'sd100, 24'sd200, 24'sd300, 24'sd7, 24'sd8, 24'sd9);
    load_coef(SLOT_GSCALE + 1, 32'h0);
    // singular accel: first row of M cleared
    load_coef(0, 32'hC000_0000);
    send_sample(24'sd100, -24'sd200, 24'sd300, 24'sd7, 24'sd8, 24'sd9);
    load_coef(0, 32'h0);
    // doubled gyro z scale halves the value and gives ties in rounding
    load_coef(SLOT_GSCALE + 2, 32'h4000_0000);
    send_sample(24'sd1, 24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd3);
    send_sample(24'sd1, 24'sd1, 24'sd1, 24'sd0, 24'sd0, -24'sd3);
    // extreme coefficients drive saturation
    load_coef(SLOT_MIS, 32'h7FFF_FFFF);
    load_coef(SLOT_ABIAS, 32'h8000_0000);
    load_coef(SLOT_GBIAS, 32'h7FFF_FFFF);
    load_coef(SLOT_GSCALE + 2, 32'hC000_0001);
    send_sample(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sh7FFFFF);
    for (int k = 0; k < NUM_COEF; k++) load_coef(k, 32'h0);

    write_step(32'h0);
    random_phase(300);
    write_step(32'h1);
    random_phase(300);
    write_step($urandom);
    random_phase(300);
    write_step(32'h0001_0000);
    random_phase(300);
    write_step(32'hFFFF_FFFF);
    random_phase(300);

    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
